// ===== sv/mi3_pkg.sv =====
`timescale 1ns / 1ps
package mi3_pkg;

	localparam int ELEM_WIDTH    = 32;
	localparam int FRAC_BITS     = 16;
	localparam int THR_WIDTH     = 31;
	localparam int FRONT_STAGES  = 5;
	localparam int LANES         = 9;

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] in_r0c0;
		logic signed [ELEM_WIDTH-1:0] in_r0c1;
		logic signed [ELEM_WIDTH-1:0] in_r0c2;
		logic signed [ELEM_WIDTH-1:0] in_r1c0;
		logic signed [ELEM_WIDTH-1:0] in_r1c1;
		logic signed [ELEM_WIDTH-1:0] in_r1c2;
		logic signed [ELEM_WIDTH-1:0] in_r2c0;
		logic signed [ELEM_WIDTH-1:0] in_r2c1;
		logic signed [ELEM_WIDTH-1:0] in_r2c2;
	} in_t;

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] out_r0c0;
		logic signed [ELEM_WIDTH-1:0] out_r0c1;
		logic signed [ELEM_WIDTH-1:0] out_r0c2;
		logic signed [ELEM_WIDTH-1:0] out_r1c0;
		logic signed [ELEM_WIDTH-1:0] out_r1c1;
		logic signed [ELEM_WIDTH-1:0] out_r1c2;
		logic signed [ELEM_WIDTH-1:0] out_r2c0;
		logic signed [ELEM_WIDTH-1:0] out_r2c1;
		logic signed [ELEM_WIDTH-1:0] out_r2c2;
		logic                         singular;
		logic                         saturated;
	} out_t;

endpackage

// ===== sv/mi3_front.sv =====
`timescale 1ns / 1ps
module mi3_front #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS
) (
	input  logic                                  clk,
	input  logic [mi3_pkg::FRONT_STAGES-1:0]      en,
	input  mi3_pkg::in_t                          mat,
	input  logic [mi3_pkg::THR_WIDTH-1:0]         thr,
	output logic [3*mi3_pkg::ELEM_WIDTH+2:0]      den_s5,
	output logic                                  sing_s5,
	output logic [2*mi3_pkg::ELEM_WIDTH+2*FRAC_BITS:0] num_s5 [mi3_pkg::LANES],
	output logic                                  neg_s5 [mi3_pkg::LANES]
);
	localparam int W  = mi3_pkg::ELEM_WIDTH;
	localparam int PW = 2 * W;
	localparam int CW = 2 * W + 1;
	localparam int DW = 3 * W + 3;
	localparam int NW = CW + 2 * FRAC_BITS;
	localparam int LW = mi3_pkg::THR_WIDTH + 2 * FRAC_BITS;
	localparam int KW = ((DW > LW + 1) ? DW : LW + 1) + 1;

	logic signed [W-1:0]  m [3][3];
	logic signed [PW-1:0] pa_s1 [3][3];
	logic signed [PW-1:0] pb_s1 [3][3];
	logic signed [W-1:0]  m0_s1 [3];
	logic signed [W-1:0]  m0_s2 [3];
	logic signed [CW-1:0] cof_s2 [3][3];
	logic signed [CW-1:0] cof_s3 [3][3];
	logic signed [CW-1:0] cof_s4 [3][3];
	logic signed [CW-1:0] tl_s3 [3];
	logic signed [CW-1:0] th_s3 [3];
	logic signed [DW-1:0] det_s4;
	logic signed [KW-1:0] det_k;
	logic signed [KW-1:0] lim_k;
	logic [LW-1:0]        lim;

	assign m[0][0] = mat.in_r0c0;
	assign m[0][1] = mat.in_r0c1;
	assign m[0][2] = mat.in_r0c2;
	assign m[1][0] = mat.in_r1c0;
	assign m[1][1] = mat.in_r1c1;
	assign m[1][2] = mat.in_r1c2;
	assign m[2][0] = mat.in_r2c0;
	assign m[2][1] = mat.in_r2c1;
	assign m[2][2] = mat.in_r2c2;

	for (genvar i = 0; i < 3; i++) begin : g_row
		localparam int I1 = (i + 1) % 3;
		localparam int I2 = (i + 2) % 3;
		for (genvar j = 0; j < 3; j++) begin : g_col
			localparam int J1 = (j + 1) % 3;
			localparam int J2 = (j + 2) % 3;
			localparam int L  = 3 * i + j;
			logic [CW-1:0] mag;
			assign mag = cof_s4[i][j][CW-1] ? CW'(-cof_s4[i][j]) : CW'(cof_s4[i][j]);
			always_ff @(posedge clk) begin
				if (en[0]) begin
					pa_s1[i][j] <= m[I1][J1] * m[I2][J2];
					pb_s1[i][j] <= m[I1][J2] * m[I2][J1];
				end
				if (en[1]) cof_s2[i][j] <= {pa_s1[i][j][PW-1], pa_s1[i][j]}
					- {pb_s1[i][j][PW-1], pb_s1[i][j]};
				if (en[2]) cof_s3[i][j] <= cof_s2[i][j];
				if (en[3]) cof_s4[i][j] <= cof_s3[i][j];
				if (en[4]) begin
					num_s5[L] <= {mag, {(2 * FRAC_BITS){1'b0}}};
					neg_s5[L] <= cof_s4[i][j][CW-1] ^ det_s4[DW-1];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en[0]) m0_s1[i] <= m[0][i];
			if (en[1]) m0_s2[i] <= m0_s1[i];
			// split the cofactor into low and high halves so each product
			// stays near element width by element width
			if (en[2]) begin
				tl_s3[i] <= m0_s2[i] * $signed({1'b0, cof_s2[0][i][W-1:0]});
				th_s3[i] <= m0_s2[i] * $signed(cof_s2[0][i][CW-1:W]);
			end
		end
	end

	// singular when -lim <= det <= lim
	assign lim   = {thr, {(2 * FRAC_BITS){1'b0}}};
	assign det_k = KW'(det_s4);
	assign lim_k = $signed(KW'(lim));

	always_ff @(posedge clk) begin
		if (en[3]) det_s4 <= ((DW'(th_s3[0]) + DW'(th_s3[1]) + DW'(th_s3[2])) <<< W)
			+ DW'(tl_s3[0]) + DW'(tl_s3[1]) + DW'(tl_s3[2]);
		if (en[4]) begin
			den_s5  <= det_s4[DW-1] ? DW'(-det_s4) : DW'(det_s4);
			sing_s5 <= (det_k <= lim_k) && (det_k >= -lim_k);
		end
	end

endmodule

// ===== sv/mi3_lane.sv =====
`timescale 1ns / 1ps
module mi3_lane #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS
) (
	input  logic                                        clk,
	input  logic [mi3_pkg::ELEM_WIDTH:0]                en,
	input  logic [2*mi3_pkg::ELEM_WIDTH+2*FRAC_BITS:0]  num,
	input  logic [3*mi3_pkg::ELEM_WIDTH+2:0]            den,
	input  logic                                        neg,
	input  logic                                        sing,
	output logic [mi3_pkg::ELEM_WIDTH-1:0]              res,
	output logic                                        sat,
	output logic                                        sing_o
);
	localparam int W  = mi3_pkg::ELEM_WIDTH;
	localparam int DW = 3 * W + 3;
	localparam int NW = 2 * W + 1 + 2 * FRAC_BITS;
	localparam int XW = (NW > DW + W) ? NW : DW + W;

	logic [XW-1:0] r_d   [W+1];
	logic [DW-1:0] den_d [W+1];
	logic [W-1:0]  q_d   [W+1];
	logic          neg_d [W+1];
	logic          sing_d [W+1];
	logic          ovf_d [W+1];

	// quotient at or above 2^W saturates whatever the sign
	always_ff @(posedge clk) begin
		if (en[0]) begin
			r_d[0]    <= XW'(num);
			den_d[0]  <= den;
			q_d[0]    <= '0;
			neg_d[0]  <= neg;
			sing_d[0] <= sing;
			ovf_d[0]  <= XW'(num) >= (XW'(den) << W);
		end
	end

	// one restoring step per stage, MSB first
	for (genvar k = 1; k <= W; k++) begin : g_step
		localparam int B = W - k;
		logic [XW-1:0] dsh;
		logic          ge;
		assign dsh = XW'(den_d[k-1]) << B;
		assign ge  = r_d[k-1] >= dsh;
		always_ff @(posedge clk) begin
			if (en[k]) begin
				r_d[k]    <= ge ? r_d[k-1] - dsh : r_d[k-1];
				q_d[k]    <= q_d[k-1] | (W'(ge) << B);
				den_d[k]  <= den_d[k-1];
				neg_d[k]  <= neg_d[k-1];
				sing_d[k] <= sing_d[k-1];
				ovf_d[k]  <= ovf_d[k-1];
			end
		end
	end

	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0] qm;
	assign qm     = q_d[W];
	assign sing_o = sing_d[W];

	always_comb begin
		sat = 1'b0;
		res = neg_d[W] ? W'(-qm) : qm;
		if (sing_d[W]) begin
			res = '0;
		end else if (ovf_d[W]) begin
			sat = 1'b1;
			res = neg_d[W] ? MINV : MAXV;
		end else if (!neg_d[W] && qm[W-1]) begin
			sat = 1'b1;
			res = MAXV;
		end else if (neg_d[W] && qm > MINV) begin
			sat = 1'b1;
			res = MINV;
		end
	end

endmodule

// ===== sv/matrix3_inverse_adjugate.sv =====
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate, signed fixed point (Q16.16 by default).
// One matrix is taken per clock and one result leaves per clock while the
// output is not stalled. A matrix passes through the front stages, the nine
// division lanes, each a restoring long divider that resolves one quotient
// bit per pipeline stage, and the output register. Stalls only hold the
// stages that are full, so empty slots collapse while the output waits. A
// matrix whose determinant magnitude is at or below the threshold (cfg_data,
// unsigned Q15.16, reset 1) comes out flagged singular with all elements
// zero; others are truncated toward zero and clipped, saturated marks a clip.
module matrix3_inverse_adjugate #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mat_valid,
	output logic                          mat_stall,
	input  mi3_pkg::in_t                  mat,
	output logic                          inv_valid,
	input  logic                          inv_stall,
	output mi3_pkg::out_t                 inv,
	input  logic                          cfg_we,
	input  logic [mi3_pkg::THR_WIDTH-1:0] cfg_data
);
	localparam int W  = mi3_pkg::ELEM_WIDTH;
	localparam int FS = mi3_pkg::FRONT_STAGES;
	localparam int NL = mi3_pkg::LANES;
	localparam int NS = FS + W + 2;
	localparam int DW = 3 * W + 3;
	localparam int NW = 2 * W + 1 + 2 * FRAC_BITS;

	logic [mi3_pkg::THR_WIDTH-1:0] thr_q;
	logic [NS-1:0] v_q;
	logic [NS-1:0] en;

	logic [DW-1:0] den_s5;
	logic          sing_s5;
	logic [NW-1:0] num_s5 [NL];
	logic          neg_s5 [NL];
	logic [W-1:0]  res [NL];
	logic          sat [NL];
	logic          sing_l [NL];
	logic          sat_any;

	// threshold write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mi3_pkg::THR_WIDTH'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// a stage may load when it or any stage after it is empty, or the
	// output transfer completes
	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = ~(&v_q[NS-1:k]) | ~inv_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= mat_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign mat_stall = ~en[0];
	assign inv_valid = v_q[NS-1];

	// products, cofactors, determinant and singular test
	mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.en      (en[FS-1:0]),
		.mat     (mat),
		.thr     (thr_q),
		.den_s5  (den_s5),
		.sing_s5 (sing_s5),
		.num_s5  (num_s5),
		.neg_s5  (neg_s5)
	);

	// one divider lane per cofactor
	for (genvar l = 0; l < NL; l++) begin : g_lane
		mi3_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.en     (en[FS+W:FS]),
			.num    (num_s5[l]),
			.den    (den_s5),
			.neg    (neg_s5[l]),
			.sing   (sing_s5),
			.res    (res[l]),
			.sat    (sat[l]),
			.sing_o (sing_l[l])
		);
	end

	always_comb begin
		sat_any = 1'b0;
		for (int l = 0; l < NL; l++) sat_any = sat_any | sat[l];
	end

	// merge lanes; lane 3i+j holds cofactor (i,j), which lands transposed
	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			inv.out_r0c0  <= res[0];
			inv.out_r1c0  <= res[1];
			inv.out_r2c0  <= res[2];
			inv.out_r0c1  <= res[3];
			inv.out_r1c1  <= res[4];
			inv.out_r2c1  <= res[5];
			inv.out_r0c2  <= res[6];
			inv.out_r1c2  <= res[7];
			inv.out_r2c2  <= res[8];
			inv.singular  <= sing_l[0];
			inv.saturated <= sat_any;
		end
	end

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv.singular |-> !inv.saturated && inv.out_r0c0 == 0
			&& inv.out_r1c1 == 0 && inv.out_r2c2 == 0 && inv.out_r0c2 == 0)
		else $error("singular result carries nonzero data");

	a_free_out: assert property (@(posedge clk) disable iff (!arst_n)
		!inv_stall |-> !mat_stall)
		else $error("input stalled while output is free");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && !mat_stall |=> v_q[0])
		else $error("transfer lost at pipeline entry");

endmodule

// ===== tb/mi3_inv_checker.sv =====
`timescale 1ns / 1ps
module mi3_inv_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mat_valid,
	input  logic                          mat_stall,
	input  mi3_pkg::in_t                  mat,
	input  logic                          inv_valid,
	input  logic                          inv_stall,
	input  mi3_pkg::out_t                 inv,
	input  logic                          cfg_we,
	input  logic [mi3_pkg::THR_WIDTH-1:0] cfg_data,
	output int                            errors,
	output int                            pending
);
	typedef logic signed [199:0] wide_t;

	logic [mi3_pkg::THR_WIDTH-1:0] threshold;
	mi3_pkg::out_t                 inverse_q[$];

	// exact adjugate inverse at a width no intermediate can overflow
	function automatic mi3_pkg::out_t invert_adjugate(mi3_pkg::in_t m,
		logic [mi3_pkg::THR_WIDTH-1:0] thr);
		wide_t              e[3][3];
		wide_t              det, adet, lim, cof, q, half;
		logic [mi3_pkg::ELEM_WIDTH-1:0] res[9];
		logic               neg, sat;
		mi3_pkg::out_t      o;
		e[0][0] = m.in_r0c0; e[0][1] = m.in_r0c1; e[0][2] = m.in_r0c2;
		e[1][0] = m.in_r1c0; e[1][1] = m.in_r1c1; e[1][2] = m.in_r1c2;
		e[2][0] = m.in_r2c0; e[2][1] = m.in_r2c1; e[2][2] = m.in_r2c2;
		det = 0;
		for (int i = 0; i < 3; i++) begin
			det = det + e[0][i] * e[1][(i+1)%3] * e[2][(i+2)%3]
			          - e[0][i] * e[1][(i+2)%3] * e[2][(i+1)%3];
		end
		adet = (det < 0) ? -det : det;
		lim = 0;
		lim[mi3_pkg::THR_WIDTH-1:0] = thr;
		lim = lim <<< (2 * mi3_pkg::FRAC_BITS);
		half = 0;
		half[mi3_pkg::ELEM_WIDTH-1] = 1'b1;
		sat = 1'b0;
		if (adet <= lim) begin
			o = '0;
			o.singular = 1'b1;
			return o;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				cof = e[(i+1)%3][(j+1)%3] * e[(i+2)%3][(j+2)%3]
				    - e[(i+1)%3][(j+2)%3] * e[(i+2)%3][(j+1)%3];
				neg = (cof < 0) != (det < 0);
				q = (((cof < 0) ? -cof : cof) <<< (2 * mi3_pkg::FRAC_BITS)) / adet;
				if (q == 0) neg = 1'b0;
				if (!neg && q > half - 1) begin
					q = half - 1;
					sat = 1'b1;
				end else if (neg && q > half) begin
					q = -half;
					sat = 1'b1;
				end else if (neg) begin
					q = -q;
				end
				// transpose: cofactor (i,j) lands at row j, column i
				res[j*3+i] = q[mi3_pkg::ELEM_WIDTH-1:0];
			end
		end
		o = {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8],
			1'b0, sat};
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mi3_pkg::out_t exp_r;
		int            bad;
		if (!arst_n) begin
			threshold <= 1;
			errors    <= 0;
			pending   <= 0;
			inverse_q.delete();
		end else begin
			bad = 0;
			if (cfg_we)
				threshold <= cfg_data;
			if (mat_valid && !mat_stall)
				inverse_q.push_back(invert_adjugate(mat, threshold));
			if (inv_valid && !inv_stall) begin
				if (inverse_q.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, inv);
					bad = bad + 1;
				end else begin
					exp_r = inverse_q.pop_front();
					for (int k = 0; k < 9; k++) begin
						if (inv[2+32*k +: 32] !== exp_r[2+32*k +: 32]) begin
							$display("%0t: element %0d expected %h actual %h", $time,
								8 - k, exp_r[2+32*k +: 32], inv[2+32*k +: 32]);
							bad = bad + 1;
						end
					end
					if (inv.singular !== exp_r.singular) begin
						$display("%0t: singular expected %b actual %b", $time,
							exp_r.singular, inv.singular);
						bad = bad + 1;
					end
					if (inv.saturated !== exp_r.saturated) begin
						$display("%0t: saturated expected %b actual %b", $time,
							exp_r.saturated, inv.saturated);
						bad = bad + 1;
					end
				end
			end
			errors  <= errors + bad;
			pending <= inverse_q.size();
		end
	end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
	localparam int LATENCY  = mi3_pkg::FRONT_STAGES + mi3_pkg::ELEM_WIDTH + 2;
	localparam int MAX_CYC  = 600000;
	localparam logic [mi3_pkg::ELEM_WIDTH-1:0] ONE  = 32'h0001_0000;
	localparam logic [mi3_pkg::ELEM_WIDTH-1:0] EMAX = 32'h7fff_ffff;
	localparam logic [mi3_pkg::ELEM_WIDTH-1:0] EMIN = 32'h8000_0000;

	logic                          clk;
	logic                          arst_n;
	logic                          mat_valid;
	logic                          mat_stall;
	mi3_pkg::in_t                  mat;
	logic                          inv_valid;
	logic                          inv_stall = 1'b0;
	mi3_pkg::out_t                 inv;
	logic                          cfg_we;
	logic [mi3_pkg::THR_WIDTH-1:0] cfg_data;
	int                            errors;
	int                            pending;
	int                            cycles = 0;
	logic                          calm;       // no stalls on the result side when set
	int                            stall_left = 0;

	matrix3_inverse_adjugate DUT (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
		.inv_valid(inv_valid), .inv_stall(inv_stall), .inv(inv),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	mi3_inv_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
		.inv_valid(inv_valid), .inv_stall(inv_stall), .inv(inv),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bound the run; a hang anywhere ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYC) begin
			$display("tb failed");
			$finish;
		end
	end

	// result-side backpressure: mostly short stalls, the odd long one
	always @(posedge clk) begin
		if (calm) begin
			inv_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			inv_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			inv_stall  <= 1'b1;
			stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
			                                             : $urandom_range(0, 3);
		end else begin
			inv_stall <= 1'b0;
		end
	end

	// hold the matrix until the transfer, then maybe leave a gap
	task automatic send_matrix(mi3_pkg::in_t m, bit gaps);
		int gap;
		mat_valid <= 1'b1;
		mat       <= m;
		@(posedge clk);
		while (mat_stall) @(posedge clk);
		gap = 0;
		if (gaps && $urandom_range(0, 2) == 0)
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
			                                   : $urandom_range(1, 3);
		if (gap > 0) begin
			mat_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain the pipe, then write the threshold while nothing is in flight
	task automatic set_threshold(logic [mi3_pkg::THR_WIDTH-1:0] thr);
		mat_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 5) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= thr;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic mi3_pkg::in_t diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		mi3_pkg::in_t m;
		m = '0;
		m.in_r0c0 = a;
		m.in_r1c1 = b;
		m.in_r2c2 = c;
		return m;
	endfunction

	// one element in a chosen flavor: full range, modest, or tiny
	function automatic logic [31:0] pick_elem(int flavor);
		case (flavor)
			0:       return $urandom;
			1:       return $signed($urandom_range(0, 2 * 8 * 65536)) - 8 * 65536;
			default: return $signed($urandom_range(0, 512)) - 256;
		endcase
	endfunction

	function automatic mi3_pkg::in_t random_matrix();
		mi3_pkg::in_t m;
		int           flavor;
		flavor = $urandom_range(0, 9);
		for (int k = 0; k < 9; k++)
			m[32*k +: 32] = pick_elem(flavor < 2 ? 0 : (flavor < 8 ? 1 : 2));
		// now and then make it singular or nearly so by copying a row
		if ($urandom_range(0, 9) == 0) begin
			m.in_r2c0 = m.in_r0c0;
			m.in_r2c1 = m.in_r0c1;
			m.in_r2c2 = m.in_r0c2 + $signed($urandom_range(0, 4)) - 2;
		end
		return m;
	endfunction

	task automatic random_phase(int count);
		for (int n = 0; n < count; n++) begin
			// advance through stretches with no idling on either side
			calm = (n % 100) >= 80;
			send_matrix(random_matrix(), !calm);
		end
		calm = 1'b0;
	endtask

	initial begin
		mi3_pkg::in_t m;
		arst_n    = 1'b0;
		mat_valid = 1'b0;
		mat       = '0;
		cfg_we    = 1'b0;
		cfg_data  = '0;
		calm      = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, zero, extremes, threshold edge, saturation
		send_matrix(diag(ONE, ONE, ONE), 1);
		send_matrix(diag(-ONE, -ONE, -ONE), 1);
		send_matrix(diag(2 * ONE, ONE / 2, ONE * 3), 1);
		send_matrix('0, 1);
		send_matrix({9{EMAX}}, 1);
		send_matrix({9{EMIN}}, 1);
		send_matrix({9{32'hffff_ffff}}, 1);
		send_matrix(diag(EMAX, EMAX, EMAX), 1);
		send_matrix(diag(EMIN, EMIN, EMIN), 1);
		send_matrix(diag(EMIN, EMAX, EMIN), 1);
		send_matrix(diag(ONE, ONE, 32'd1), 1);      // right at the threshold
		send_matrix(diag(ONE, ONE, 32'd2), 1);      // just above it
		send_matrix(diag(ONE, ONE, -32'sd2), 1);
		send_matrix(diag(32'd256, 32'd256, 32'd256), 1);
		send_matrix(diag(32'd300, 32'd300, -32'sd300), 1);
		m = diag(ONE, ONE, ONE);
		m.in_r0c1 = 32'h0002_8000;
		m.in_r1c2 = -32'sh0001_4000;
		m.in_r2c0 = 32'h0000_0003;
		send_matrix(m, 1);
		m = {EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX};
		send_matrix(m, 1);
		m = {32'h5555_5555, 32'haaaa_aaaa, 32'h0, 32'h0, 32'h5555_5555, 32'haaaa_aaaa,
			32'haaaa_aaaa, 32'h0, 32'h5555_5555};
		send_matrix(m, 1);
		random_phase(220);

		set_threshold('0);
		send_matrix('0, 1);
		send_matrix(diag(32'd1, 32'd1, 32'd1), 1);
		random_phase(240);

		set_threshold({mi3_pkg::THR_WIDTH{1'b1}});
		send_matrix(diag(EMAX, EMAX, EMAX), 1);
		send_matrix(diag(EMIN, EMIN, EMIN), 1);
		random_phase(240);

		set_threshold(mi3_pkg::THR_WIDTH'($urandom_range(0, 16)));
		random_phase(240);

		set_threshold(31'd1);
		random_phase(240);

		mat_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

// ===== matrix3_inverse_adjugate.f =====
sv/mi3_pkg.sv
sv/mi3_front.sv
sv/mi3_lane.sv
sv/matrix3_inverse_adjugate.sv
tb/mi3_inv_checker.sv
tb/tb.sv
